/* src/pgws_pkg.sv */
package pgws_pkg;

    localparam int MAX_GROUPS = 8;
    localparam int NUM_TEMPS  = 4;
    localparam int GW  = $clog2(MAX_GROUPS);
    localparam int TW  = $clog2(NUM_TEMPS);
    localparam int CW  = $clog2(MAX_GROUPS + 1);
    localparam int BAW = GW + TW;
    localparam int BDEPTH = MAX_GROUPS * NUM_TEMPS;

    localparam logic [31:0] MIN_START  = 32'h7fff_ffff;
    localparam logic [31:0] PAGE_RESET = 32'd10240;

    localparam logic [1:0] REQ_SELECT   = 2'd0;
    localparam logic [1:0] REQ_STATUS   = 2'd1;
    localparam logic [1:0] REQ_ADVANCE  = 2'd2;
    localparam logic [1:0] REQ_REASSIGN = 2'd3;

    localparam logic [2:0] CFG_GROUP_COUNT = 3'd0;
    localparam logic [2:0] CFG_IDEAL_PAGES = 3'd1;
    localparam logic [2:0] CFG_MAX_PAGES   = 3'd2;
    localparam logic [2:0] CFG_PAGE_SLACK  = 3'd3;
    localparam logic [2:0] CFG_RESERVE     = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  temperature;
        logic        is_gc_write;
        logic        is_retry;
        logic [2:0]  source_group;
        logic [2:0]  target_group;
        logic        group_is_good;
        logic [31:0] valid_pages;
        logic [15:0] free_units;
    } t_req;

    typedef struct packed {
        logic [2:0]  chosen_group;
        logic        found;
        logic [63:0] birthday_value;
    } t_res;

    typedef struct packed {
        logic        good;
        logic [31:0] pages;
        logic [15:0] free;
    } t_stat;

    typedef struct packed {
        logic [GW-1:0] rd_addr;
        logic          we;
        logic [GW-1:0] wr_addr;
        t_stat         wr_data;
    } t_st_cmd;

    typedef struct packed {
        logic [BAW-1:0] rd_addr;
        logic           we;
        logic [BAW-1:0] wr_addr;
        logic [63:0]    wr_data;
    } t_bd_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOT,
        ST_PICK,
        ST_BMAX,
        ST_BREA,
        ST_DONE
    } t_state;

    localparam t_stat STAT_RESET = '{good: 1'b1, pages: 32'd0, free: 16'd0};

    function automatic logic [63:0] bday_init(input logic [TW-1:0] t);
        bday_init = {{(64 - TW){1'b0}}, t} << (63 - TW);
    endfunction

endpackage

/* src/pgws_status_store.sv */
module pgws_status_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgws_pkg::t_st_cmd i_cmd,
    output pgws_pkg::t_stat   o_q
);

    pgws_pkg::t_stat mem [pgws_pkg::MAX_GROUPS];
    logic [pgws_pkg::MAX_GROUPS-1:0] r_vld;
    pgws_pkg::t_stat r_rd;
    logic r_rv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd <= mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rv  <= 1'b0;
        end else begin
            if (i_cmd.we) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
            r_rv <= r_vld[i_cmd.rd_addr];
        end
    end

    // unwritten entries read as the reset status
    assign o_q = r_rv ? r_rd : pgws_pkg::STAT_RESET;

endmodule

/* src/pgws_bday_store.sv */
module pgws_bday_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgws_pkg::t_bd_cmd i_cmd,
    output logic [63:0]       o_q
);

    logic [63:0] mem [pgws_pkg::BDEPTH];
    logic [pgws_pkg::BDEPTH-1:0] r_vld;
    logic [63:0] r_rd;
    logic r_rv;
    logic [pgws_pkg::TW-1:0] r_rt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        r_rd <= mem[i_cmd.rd_addr];
        r_rt <= i_cmd.rd_addr[pgws_pkg::TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rv  <= 1'b0;
        end else begin
            if (i_cmd.we) begin
                r_vld[i_cmd.wr_addr] <= 1'b1;
            end
            r_rv <= r_vld[i_cmd.rd_addr];
        end
    end

    assign o_q = r_rv ? r_rd : pgws_pkg::bday_init(r_rt);

endmodule

/* src/pgws_ctrl.sv */
module pgws_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pgws_pkg::t_req     i_req,
    output logic               o_res_valid,
    output pgws_pkg::t_res     o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output pgws_pkg::t_st_cmd  o_st,
    input  pgws_pkg::t_stat    i_st_q,
    output pgws_pkg::t_bd_cmd  o_bd,
    input  logic [63:0]        i_bd_q
);

    localparam int GW = pgws_pkg::GW;
    localparam int TW = pgws_pkg::TW;
    localparam int CW = pgws_pkg::CW;
    localparam logic [TW-1:0] HOT = TW'(pgws_pkg::NUM_TEMPS - 1);

    pgws_pkg::t_state r_state, n_state;
    pgws_pkg::t_req   r_req, n_req;
    pgws_pkg::t_res   r_res, n_res;

    logic [3:0]  r_gcount;
    logic [31:0] r_ideal, r_maxp;
    logic [15:0] r_slack, r_reserve;
    logic [31:0] r_rr [pgws_pkg::NUM_TEMPS];

    logic [31:0] r_dq, n_dq;
    logic [CW-1:0] r_rem, n_rem, div_rem;
    logic [1:0]  r_dstep, n_dstep;
    logic [GW-1:0] r_base, n_base;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [TW-1:0] r_k, n_k;
    logic        r_iss_end, n_iss_end;
    logic        r_dv, n_dv;
    logic [CW-1:0] r_dj, n_dj;
    logic [GW-1:0] r_didx, n_didx;
    logic [TW-1:0] r_dk, n_dk;
    pgws_pkg::t_stat r_prev, n_prev;
    logic [63:0] r_prev_bd, n_prev_bd;
    logic [GW-1:0] r_prev_idx, n_prev_idx;
    logic [GW-1:0] r_lg, n_lg;
    logic        r_lgv, n_lgv;
    logic [GW-1:0] r_best, n_best;
    logic        r_bestv, n_bestv;
    logic [31:0] r_best_pages, n_best_pages;
    logic [63:0] r_max, n_max;

    logic [CW-1:0] n_used;
    logic [GW-1:0] iss_addr;
    logic [TW-1:0] iss_temp;
    logic          issue;
    logic          rr_we;
    logic [31:0]   rr_new;

    always_comb begin
        if (r_gcount == 4'd0) begin
            n_used = CW'(1);
        end else if (r_gcount > 4'(pgws_pkg::MAX_GROUPS)) begin
            n_used = CW'(pgws_pkg::MAX_GROUPS);
        end else begin
            n_used = CW'(r_gcount);
        end
    end

    function automatic logic [GW-1:0] wrap(input logic [GW-1:0] b, input logic [CW-1:0] c,
                                           input logic [CW-1:0] n);
        logic [CW:0] s;
        s = {{(CW + 1 - GW){1'b0}}, b} + {1'b0, c};
        if (s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        wrap = s[GW-1:0];
    endfunction

    function automatic logic in_bound(input logic [31:0] p, input logic [31:0] ideal,
                                      input logic [15:0] slack);
        in_bound = {1'b0, p} <= ({1'b0, ideal} + {17'd0, slack});
    endfunction

    // eight remainder steps per cycle, msb first
    always_comb begin
        logic [CW:0] tmp;
        logic [CW-1:0] rem;
        rem = r_rem;
        for (int b = 0; b < 8; b++) begin
            tmp = {rem, r_dq[31 - b]};
            if (tmp >= {1'b0, n_used}) begin
                tmp = tmp - {1'b0, n_used};
            end
            rem = tmp[CW-1:0];
        end
        div_rem = rem;
    end

    assign rr_new = r_rr[i_req.temperature[TW-1:0]] + 32'd1;

    always_comb begin
        logic hit;
        logic leave;
        logic [GW-1:0] lg;
        logic lgv;
        logic [63:0] v;
        logic [63:0] m;
        hit   = 1'b0;
        leave = 1'b0;
        lg    = r_lg;
        lgv   = r_lgv;
        v     = '0;
        m     = '0;

        n_state      = r_state;
        n_req        = r_req;
        n_res        = r_res;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_dstep      = r_dstep;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_iss_end    = r_iss_end;
        n_dv         = 1'b0;
        n_dj         = r_cnt;
        n_dk         = r_k;
        n_prev       = r_prev;
        n_prev_bd    = r_prev_bd;
        n_prev_idx   = r_prev_idx;
        n_lg         = r_lg;
        n_lgv        = r_lgv;
        n_best       = r_best;
        n_bestv      = r_bestv;
        n_best_pages = r_best_pages;
        n_max        = r_max;
        rr_we        = 1'b0;
        issue        = 1'b0;
        iss_addr     = '0;
        iss_temp     = HOT;

        o_st         = '0;
        o_bd         = '0;

        case (r_state)
            pgws_pkg::ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_res = '{chosen_group: i_req.target_group, found: 1'b0,
                              birthday_value: 64'd0};
                    n_cnt = '0;
                    n_k   = '0;
                    n_iss_end = 1'b0;
                    n_max = '0;
                    if (i_req.req_type == pgws_pkg::REQ_SELECT) begin
                        rr_we   = 1'b1;
                        n_dq    = rr_new;
                        n_rem   = '0;
                        n_dstep = '0;
                        n_state = pgws_pkg::ST_DIV;
                    end else if ({1'b0, i_req.target_group} >= 4'(n_used)) begin
                        n_state = pgws_pkg::ST_DONE;
                    end else begin
                        n_res.found = 1'b1;
                        case (i_req.req_type)
                            pgws_pkg::REQ_STATUS: begin
                                o_st.we      = 1'b1;
                                o_st.wr_addr = i_req.target_group[GW-1:0];
                                o_st.wr_data = '{good: i_req.group_is_good,
                                                 pages: i_req.valid_pages,
                                                 free: i_req.free_units};
                                n_state = pgws_pkg::ST_DONE;
                            end
                            pgws_pkg::REQ_ADVANCE:  n_state = pgws_pkg::ST_BMAX;
                            default:                n_state = pgws_pkg::ST_BREA;
                        endcase
                    end
                end
            end

            pgws_pkg::ST_DIV: begin
                n_rem   = div_rem;
                n_dq    = r_dq << 8;
                n_dstep = r_dstep + 2'd1;
                if (r_dstep == 2'd3) begin
                    n_base = div_rem[GW-1:0];
                    n_cnt  = '0;
                    n_lgv  = 1'b0;
                    n_bestv = 1'b0;
                    n_best_pages = pgws_pkg::MIN_START;
                    n_state = (r_req.temperature[TW-1:0] == HOT) ? pgws_pkg::ST_HOT
                                                                 : pgws_pkg::ST_PICK;
                end
            end

            pgws_pkg::ST_HOT: begin
                if (r_dv) begin
                    if (r_dj == '0) begin
                        n_prev     = i_st_q;
                        n_prev_bd  = i_bd_q;
                        n_prev_idx = r_didx;
                    end else begin
                        hit = r_prev.good && i_st_q.good &&
                              (r_req.is_retry || ((r_prev_bd <= i_bd_q) &&
                               in_bound(r_prev.pages, r_ideal, r_slack)));
                        if (hit) begin
                            leave = 1'b1;
                            n_res.chosen_group = r_prev_idx;
                            n_res.found = 1'b1;
                            n_state = pgws_pkg::ST_DONE;
                        end else begin
                            if (r_prev.good) begin
                                lg  = r_prev_idx;
                                lgv = 1'b1;
                            end
                            n_lg       = lg;
                            n_lgv      = lgv;
                            n_prev     = i_st_q;
                            n_prev_bd  = i_bd_q;
                            n_prev_idx = r_didx;
                            if (r_dj == n_used) begin
                                leave = 1'b1;
                                n_cnt = '0;
                                if (i_st_q.good) begin
                                    n_base  = r_didx;
                                    n_state = pgws_pkg::ST_PICK;
                                end else if (lgv) begin
                                    n_base  = lg;
                                    n_state = pgws_pkg::ST_PICK;
                                end else begin
                                    n_res.chosen_group = '0;
                                    n_res.found = 1'b0;
                                    n_state = pgws_pkg::ST_DONE;
                                end
                            end
                        end
                    end
                end
                // one read past the last group: the wrap back to the start
                if (!leave && r_cnt <= n_used) begin
                    issue    = 1'b1;
                    iss_addr = wrap(r_base, r_cnt, n_used);
                    n_cnt    = r_cnt + CW'(1);
                end
            end

            pgws_pkg::ST_PICK: begin
                if (r_dv) begin
                    if (r_req.is_gc_write) begin
                        hit = i_st_q.good && ((r_req.source_group == 3'(r_didx)) ||
                              (i_st_q.free > r_reserve));
                    end else if (i_st_q.good) begin
                        hit = r_req.is_retry || in_bound(i_st_q.pages, r_ideal, r_slack);
                        if (!hit && i_st_q.pages < r_best_pages) begin
                            n_best       = r_didx;
                            n_bestv      = 1'b1;
                            n_best_pages = i_st_q.pages;
                        end
                    end
                    if (hit) begin
                        leave = 1'b1;
                        n_res.chosen_group = 3'(r_didx);
                        n_res.found = 1'b1;
                        n_state = pgws_pkg::ST_DONE;
                    end else if (r_dj == n_used - CW'(1)) begin
                        leave = 1'b1;
                        n_state = pgws_pkg::ST_DONE;
                        if (!r_req.is_gc_write && n_bestv && n_best_pages <= r_maxp) begin
                            n_res.chosen_group = 3'(n_best);
                            n_res.found = 1'b1;
                        end else begin
                            n_res.chosen_group = '0;
                            n_res.found = 1'b0;
                        end
                    end
                end
                if (!leave && r_cnt < n_used) begin
                    issue    = 1'b1;
                    iss_addr = wrap(r_base, r_cnt, n_used);
                    n_cnt    = r_cnt + CW'(1);
                end
            end

            pgws_pkg::ST_BMAX: begin
                iss_temp = r_req.temperature[TW-1:0];
                if (r_dv) begin
                    v = (r_didx == r_req.target_group[GW-1:0]) ? i_bd_q + 64'd1 : i_bd_q;
                    m = (v > r_max) ? v : r_max;
                    n_max = m;
                    if (r_dj == n_used - CW'(1)) begin
                        o_bd.we      = 1'b1;
                        o_bd.wr_addr = {r_req.target_group[GW-1:0], iss_temp};
                        o_bd.wr_data = m;
                        n_res.birthday_value = m;
                        n_state = pgws_pkg::ST_DONE;
                    end
                end
                if (r_cnt < n_used) begin
                    issue    = 1'b1;
                    iss_addr = r_cnt[GW-1:0];
                    n_cnt    = r_cnt + CW'(1);
                end
            end

            pgws_pkg::ST_BREA: begin
                iss_temp = r_k;
                if (r_dv) begin
                    m = r_max;
                    if (r_didx != r_req.target_group[GW-1:0] && i_bd_q > r_max) begin
                        m = i_bd_q;
                    end
                    n_max = m;
                    if ({1'b0, r_didx} == n_used - CW'(1)) begin
                        o_bd.we      = 1'b1;
                        o_bd.wr_addr = {r_req.target_group[GW-1:0], r_dk};
                        o_bd.wr_data = m;
                        n_max = '0;
                        if (r_dk == HOT) begin
                            n_state = pgws_pkg::ST_DONE;
                        end
                    end
                end
                if (!r_iss_end) begin
                    issue    = 1'b1;
                    iss_addr = r_cnt[GW-1:0];
                    if (r_cnt == n_used - CW'(1)) begin
                        n_cnt = '0;
                        if (r_k == HOT) begin
                            n_iss_end = 1'b1;
                        end else begin
                            n_k = r_k + TW'(1);
                        end
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end

            pgws_pkg::ST_DONE: begin
                n_state = pgws_pkg::ST_IDLE;
            end

            default: begin
                n_state = pgws_pkg::ST_IDLE;
            end
        endcase

        n_dv   = issue;
        n_didx = iss_addr;
        n_dk   = iss_temp;
        o_st.rd_addr = iss_addr;
        o_bd.rd_addr = {iss_addr, iss_temp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pgws_pkg::ST_IDLE;
            r_dv      <= 1'b0;
            r_gcount  <= 4'd8;
            r_ideal   <= pgws_pkg::PAGE_RESET;
            r_maxp    <= pgws_pkg::PAGE_RESET;
            r_slack   <= 16'd256;
            r_reserve <= 16'd8;
            for (int t = 0; t < pgws_pkg::NUM_TEMPS; t++) begin
                r_rr[t] <= '1;
            end
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            if (rr_we) begin
                r_rr[i_req.temperature[TW-1:0]] <= rr_new;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pgws_pkg::CFG_GROUP_COUNT: r_gcount  <= i_cfg_data[3:0];
                    pgws_pkg::CFG_IDEAL_PAGES: r_ideal   <= i_cfg_data;
                    pgws_pkg::CFG_MAX_PAGES:   r_maxp    <= i_cfg_data;
                    pgws_pkg::CFG_PAGE_SLACK:  r_slack   <= i_cfg_data[15:0];
                    pgws_pkg::CFG_RESERVE:     r_reserve <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_res        <= n_res;
        r_dq         <= n_dq;
        r_rem        <= n_rem;
        r_dstep      <= n_dstep;
        r_base       <= n_base;
        r_cnt        <= n_cnt;
        r_k          <= n_k;
        r_iss_end    <= n_iss_end;
        r_dj         <= n_dj;
        r_didx       <= n_didx;
        r_dk         <= n_dk;
        r_prev       <= n_prev;
        r_prev_bd    <= n_prev_bd;
        r_prev_idx   <= n_prev_idx;
        r_lg         <= n_lg;
        r_lgv        <= n_lgv;
        r_best       <= n_best;
        r_bestv      <= n_bestv;
        r_best_pages <= n_best_pages;
        r_max        <= n_max;
    end

    assign busy        = (r_state != pgws_pkg::ST_IDLE);
    assign o_res_valid = (r_state == pgws_pkg::ST_DONE);
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.found) |-> ({1'b0, o_res.chosen_group} < 4'(n_used)))
        else $error("chosen group beyond group count");

    a_bd_write_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bd.we |-> (o_bd.wr_addr[pgws_pkg::BAW-1:TW] == r_req.target_group[GW-1:0]))
        else $error("birthday write off the target group");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

endmodule

/* src/protection_group_write_selector.sv */
// channel  | direction | handshake                      | word
// request  | in        | start, busy (accept: start&!busy) | i_req (t_req)
// result   | out       | o_res_valid, one-cycle strobe  | o_res (t_res)
// config   | in        | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
// One request at a time; the next word is taken in the idle state that follows the
// result strobe. Select: a remainder of the round-robin counter (8 bits per cycle),
// up to n+1 status reads at the hottest layer, and the n-read gc/normal scan, then
// the result. Status update: a single status store write. Advance: n birthday reads.
// Reassign: 4n birthday reads (one birthday read per cycle).
// Synchronous active-low reset; the stores clear through valid bits, no sweep.
// The receiver cannot stall; results are dropped into a one-cycle strobe.
module protection_group_write_selector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pgws_pkg::t_req i_req,
    output logic           o_res_valid,
    output pgws_pkg::t_res o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    pgws_pkg::t_st_cmd st_cmd;
    pgws_pkg::t_stat   st_q;
    pgws_pkg::t_bd_cmd bd_cmd;
    logic [63:0]       bd_q;

    pgws_status_store u_status (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (st_cmd),
        .o_q     (st_q)
    );

    pgws_bday_store u_bday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bd_cmd),
        .o_q     (bd_q)
    );

    pgws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_st        (st_cmd),
        .i_st_q      (st_q),
        .o_bd        (bd_cmd),
        .i_bd_q      (bd_q)
    );

endmodule

/* tb/pgws_checker.sv */
`timescale 1ns / 100ps

module pgws_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  pgws_pkg::t_req i_req,
    input  logic           o_res_valid,
    input  pgws_pkg::t_res o_res,
    input  logic           i_cfg_valid,
    input  logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);

    logic [3:0]  group_count;
    logic [31:0] ideal_pages;
    logic [31:0] max_pages;
    logic [15:0] page_slack;
    logic [15:0] reserve_free;

    logic [31:0] rr_cnt   [pgws_pkg::NUM_TEMPS];
    logic        grp_good [pgws_pkg::MAX_GROUPS];
    logic [31:0] grp_pages[pgws_pkg::MAX_GROUPS];
    logic [15:0] grp_free [pgws_pkg::MAX_GROUPS];
    logic [63:0] grp_bday [pgws_pkg::MAX_GROUPS][pgws_pkg::NUM_TEMPS];

    pgws_pkg::t_res expected_words[$];

    function automatic int groups_in_use();
        if (group_count == 0) return 1;
        if (group_count > pgws_pkg::MAX_GROUPS) return pgws_pkg::MAX_GROUPS;
        return group_count;
    endfunction

    function automatic bit under_page_bound(int g);
        return {32'd0, grp_pages[g]} <= {32'd0, ideal_pages} + {48'd0, page_slack};
    endfunction

    function automatic logic [63:0] bday_max(int n, int t, int skip);
        logic [63:0] m;
        m = '0;
        for (int g = 0; g < n; g++)
            if (g != skip && grp_bday[g][t] > m) m = grp_bday[g][t];
        return m;
    endfunction

    // returns -1 when no group qualifies
    function automatic int choose_group(int t, bit gc, bit retry, int src);
        int n;
        int sel;
        int nx;
        int last_good;
        int best;
        int i;
        logic [31:0] best_pages;
        n = groups_in_use();
        last_good = -1;
        rr_cnt[t] = rr_cnt[t] + 32'd1;
        sel = int'(rr_cnt[t] % n);
        if (t == pgws_pkg::NUM_TEMPS - 1) begin
            for (i = 0; i < n; i++) begin
                nx = (sel + 1) % n;
                if (grp_good[sel]) begin
                    last_good = sel;
                    if (grp_good[nx]
                        && (retry || grp_bday[sel][t] <= grp_bday[nx][t])
                        && (retry || under_page_bound(sel)))
                        break;
                end
                sel = (sel + 1) % n;
            end
            if (i < n) return sel;
            if (!grp_good[sel]) begin
                if (last_good < 0) return -1;
                sel = last_good;
            end
        end
        if (gc) begin
            for (i = 0; i < n; i++) begin
                if (grp_good[sel] && (src == sel || grp_free[sel] > reserve_free))
                    return sel;
                sel = (sel + 1) % n;
            end
            return -1;
        end
        best = -1;
        best_pages = pgws_pkg::MIN_START;
        for (i = 0; i < n; i++) begin
            if (grp_good[sel]) begin
                if (retry || under_page_bound(sel)) return sel;
                if (grp_pages[sel] < best_pages) begin
                    best = sel;
                    best_pages = grp_pages[sel];
                end
            end
            sel = (sel + 1) % n;
        end
        if (best < 0 || best_pages > max_pages) return -1;
        return best;
    endfunction

    function automatic pgws_pkg::t_res predict_word(pgws_pkg::t_req rq);
        pgws_pkg::t_res r;
        int n;
        int t;
        int tg;
        int pick;
        n = groups_in_use();
        t = rq.temperature;
        tg = rq.target_group;
        r.chosen_group = rq.target_group;
        r.found = 1'b0;
        r.birthday_value = '0;
        if (rq.req_type == pgws_pkg::REQ_SELECT) begin
            pick = choose_group(t, rq.is_gc_write, rq.is_retry, rq.source_group);
            if (pick >= 0) begin
                r.found = 1'b1;
                r.chosen_group = pick[2:0];
            end else begin
                r.chosen_group = '0;
            end
        end else if (tg < n) begin
            r.found = 1'b1;
            case (rq.req_type)
                pgws_pkg::REQ_STATUS: begin
                    grp_good[tg] = rq.group_is_good;
                    grp_pages[tg] = rq.valid_pages;
                    grp_free[tg] = rq.free_units;
                end
                pgws_pkg::REQ_ADVANCE: begin
                    grp_bday[tg][t] = grp_bday[tg][t] + 64'd1;
                    grp_bday[tg][t] = bday_max(n, t, pgws_pkg::MAX_GROUPS);
                    r.birthday_value = grp_bday[tg][t];
                end
                default: begin
                    for (int k = 0; k < pgws_pkg::NUM_TEMPS; k++)
                        grp_bday[tg][k] = bday_max(n, k, tg);
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        pgws_pkg::t_res want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            group_count = 4'd8;
            ideal_pages = pgws_pkg::PAGE_RESET;
            max_pages = pgws_pkg::PAGE_RESET;
            page_slack = 16'd256;
            reserve_free = 16'd8;
            for (int t = 0; t < pgws_pkg::NUM_TEMPS; t++) rr_cnt[t] = '1;
            for (int g = 0; g < pgws_pkg::MAX_GROUPS; g++) begin
                grp_good[g] = 1'b1;
                grp_pages[g] = '0;
                grp_free[g] = '0;
                for (int t = 0; t < pgws_pkg::NUM_TEMPS; t++)
                    grp_bday[g][t] = 64'(t) << 61;
            end
            expected_words.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pgws_pkg::CFG_GROUP_COUNT: group_count = i_cfg_data[3:0];
                    pgws_pkg::CFG_IDEAL_PAGES: ideal_pages = i_cfg_data;
                    pgws_pkg::CFG_MAX_PAGES:   max_pages = i_cfg_data;
                    pgws_pkg::CFG_PAGE_SLACK:  page_slack = i_cfg_data[15:0];
                    pgws_pkg::CFG_RESERVE:     reserve_free = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy) expected_words.push_back(predict_word(i_req));
            if (o_res_valid) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_res.chosen_group !== want.chosen_group) begin
                        $error("chosen_group: expected %0d, actual %0d",
                               want.chosen_group, o_res.chosen_group);
                        o_fail_count++;
                    end
                    if (o_res.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, o_res.found);
                        o_fail_count++;
                    end
                    if (o_res.birthday_value !== want.birthday_value) begin
                        $error("birthday_value: expected %h, actual %h",
                               want.birthday_value, o_res.birthday_value);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

/* tb/tb_protection_group_write_selector.sv */
`timescale 1ns / 100ps

module tb_protection_group_write_selector;

    localparam int IDLE_LIMIT = 3000;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    pgws_pkg::t_req i_req;
    logic           o_res_valid;
    pgws_pkg::t_res o_res;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [31:0]    i_cfg_data;
    int             fail_count;
    int             pending;
    int             idle_pct;
    int             quiet_cycles;

    protection_group_write_selector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_valid(o_res_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pgws_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_valid(o_res_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic pgws_pkg::t_req make_req(logic [1:0] rt, logic [1:0] temp, bit gc,
                                                bit retry, logic [2:0] src, logic [2:0] tgt,
                                                bit good, logic [31:0] pages,
                                                logic [15:0] fr);
        pgws_pkg::t_req r;
        r.req_type = rt;
        r.temperature = temp;
        r.is_gc_write = gc;
        r.is_retry = retry;
        r.source_group = src;
        r.target_group = tgt;
        r.group_is_good = good;
        r.valid_pages = pages;
        r.free_units = fr;
        return r;
    endfunction

    function automatic pgws_pkg::t_req random_req();
        pgws_pkg::t_req r;
        int pick;
        r = $bits(pgws_pkg::t_req)'({$urandom, $urandom});
        r.valid_pages = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 55) r.req_type = pgws_pkg::REQ_SELECT;
        else if (pick < 80) r.req_type = pgws_pkg::REQ_STATUS;
        else if (pick < 92) r.req_type = pgws_pkg::REQ_ADVANCE;
        else r.req_type = pgws_pkg::REQ_REASSIGN;
        if ($urandom_range(0, 99) < 35) r.temperature = 2'd3;
        r.group_is_good = $urandom_range(0, 99) < 80;
        case ($urandom_range(0, 5))
            0: r.valid_pages = '0;
            1: r.valid_pages = $urandom_range(0, 300);
            2: r.valid_pages = 32'h7fff_ffff - $urandom_range(0, 1);
            3: r.valid_pages = $urandom_range(0, 6000);
            4: r.valid_pages = $urandom_range(0, 12000);
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) r.free_units = 16'($urandom_range(0, 120));
        return r;
    endfunction

    // the sender holds off for each cycle with probability idle_pct
    task automatic gap();
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send(pgws_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        @(posedge i_clk);
    endtask

    initial begin
        pgws_pkg::t_req directed[$];
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pgws_pkg::CFG_GROUP_COUNT;
        i_cfg_data <= '0;
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup: hot scan, gc, normal, updates, birthdays
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd3, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd0, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd1, 1, 0, 3'd1, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_STATUS, 2'd0, 0, 0, 3'd0, 3'd1, 1, '1, '1));
        directed.push_back(make_req(pgws_pkg::REQ_STATUS, 2'd0, 0, 0, 3'd0, 3'd2, 0,
                                    32'h7fff_ffff, 16'd9));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd2, 1, 0, 3'd7, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd2, 0, 1, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_ADVANCE, 2'd3, 0, 0, 3'd0, 3'd7, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_ADVANCE, 2'd0, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd3, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd3, 1, 1, 3'd3, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_REASSIGN, 2'd1, 0, 0, 3'd0, 3'd4, 0, 0, 0));
        for (int g = 0; g < 8; g++)
            directed.push_back(make_req(pgws_pkg::REQ_STATUS, 2'd0, 0, 0, 3'd0, g[2:0], 0,
                                        32'd20000, 16'd0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd3, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd0, 1, 0, 3'd2, 3'd0, 0, 0, 0));
        directed.push_back(make_req(pgws_pkg::REQ_STATUS, 2'd0, 0, 0, 3'd0, 3'd5, 1,
                                    32'd11000, 16'd0));
        directed.push_back(make_req(pgws_pkg::REQ_SELECT, 2'd1, 0, 0, 3'd0, 3'd0, 0, 0, 0));
        foreach (directed[i]) send(directed[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'd8);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, 32'd100);
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, 32'd5000);
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, 32'd10);
                    cfg_write(pgws_pkg::CFG_RESERVE, 32'd8);
                end
                1: begin
                    // zero group count acts as one
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'd0);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, 32'd0);
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, 32'd0);
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, 32'd0);
                    cfg_write(pgws_pkg::CFG_RESERVE, 32'd0);
                end
                2: begin
                    // above-max group count clamps
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'hffff_ffff);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, 32'hffff_ffff);
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, 32'hffff_ffff);
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, 32'h0000_ffff);
                    cfg_write(pgws_pkg::CFG_RESERVE, 32'h0000_ffff);
                end
                3: begin
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'd3);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, 32'd50);
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, 32'd200);
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, 32'd5);
                    cfg_write(pgws_pkg::CFG_RESERVE, 32'd60);
                end
                4: begin
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'd5);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, $urandom_range(0, 3000));
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, $urandom_range(0, 12000));
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, $urandom_range(0, 400));
                    cfg_write(pgws_pkg::CFG_RESERVE, $urandom_range(0, 100));
                end
                default: begin
                    cfg_write(pgws_pkg::CFG_GROUP_COUNT, 32'd1);
                    cfg_write(pgws_pkg::CFG_IDEAL_PAGES, 32'd4096);
                    cfg_write(pgws_pkg::CFG_MAX_PAGES, 32'd8000);
                    cfg_write(pgws_pkg::CFG_PAGE_SLACK, 32'd256);
                    cfg_write(pgws_pkg::CFG_RESERVE, 32'd30);
                end
            endcase
            i_cfg_valid <= 1'b0;
            idle_pct = (ph < 2) ? 34 : (ph < 4) ? 83 : 0;
            for (int k = 0; k < 240; k++) begin
                gap();
                send(random_req());
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
